FILE: src/assert_macros.svh
// Assertion macros shared by the accent color picker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/icp_pkg.sv
// Shared types, constants and helper functions of the accent color picker.
`timescale 1ns / 1ps
package icp_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_STRIDE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_RED   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_GREEN = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BLUE  = 4'd3;

  localparam logic [15:0] STRIDE_RESET = 16'd1;

  // Brightness classes of the chosen candidate.
  localparam logic [9:0]  BRIGHT_SUM = 10'd638;
  localparam logic [9:0]  DARK_SUM   = 10'd76;
  localparam logic [10:0] DARK_BASE  = 11'd1785;

  // 2^23 / 255 rounded up; exact quotient for any 16-bit dividend.
  localparam logic [15:0] RECIP_255 = 16'd32897;

  // Color of the chosen candidate handed to the output stage.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cand_t;

  // Default color from the configuration registers.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // floor(p / 510) as floor(floor(p / 2) / 255), the latter by reciprocal.
  function automatic logic [7:0] div510(input logic [16:0] p);
    logic [31:0] prod;
    prod = 32'(p[16:1]) * 32'(RECIP_255);
    return prod[30:23];
  endfunction

endpackage

FILE: src/icp_select.sv
// Input register and best-saturation candidate tracker.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icp_select
  import icp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_valid,
  output logic        pix_ready,
  input  logic [7:0]  pix_red,
  input  logic [7:0]  pix_green,
  input  logic [7:0]  pix_blue,
  input  logic        pix_last,
  input  logic [15:0] sample_stride,
  output logic        cand_valid,
  input  logic        cand_ready,
  output cand_t       cand
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_last;

  // Tracking state for the current icon.
  logic [15:0] stride_count;
  logic [7:0]  best_red;
  logic [7:0]  best_green;
  logic [7:0]  best_blue;
  logic [7:0]  best_delta;
  logic [7:0]  best_max;
  logic        first_pending;

  logic        pop;
  logic        candidate;
  logic [7:0]  mx_rg;
  logic [7:0]  mn_rg;
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic        take;
  logic [15:0] stride_count_next;
  cand_t       best_next;
  logic [7:0]  best_delta_next;
  logic [7:0]  best_max_next;
  logic        first_pending_next;

  // A pixel leaves the input register unless it ends an icon and the result slot is full.
  assign pop       = in_valid && (!in_last || !cand_valid || cand_ready);
  assign pix_ready = !in_valid || pop;

  // Candidate selection and saturation compare.
  always_comb begin
    candidate = first_pending || (stride_count == 16'd0);
    mx_rg = (in_red > in_green) ? in_red : in_green;
    mn_rg = (in_red < in_green) ? in_red : in_green;
    mx    = (mx_rg > in_blue) ? mx_rg : in_blue;
    mn    = (mn_rg < in_blue) ? mn_rg : in_blue;
    delta = mx - mn;
    if (first_pending) begin
      take = 1'b1;
    end else if (best_delta == 8'd0) begin
      take = (delta != 8'd0);
    end else begin
      take = (16'(delta) * 16'(best_max)) > (16'(best_delta) * 16'(mx));
    end
    if (candidate) begin
      stride_count_next = (sample_stride == 16'd0) ? 16'd0 : sample_stride - 16'd1;
    end else begin
      stride_count_next = stride_count - 16'd1;
    end
    if (candidate && take) begin
      best_next       = '{red: in_red, green: in_green, blue: in_blue};
      best_delta_next = delta;
      best_max_next   = mx;
    end else begin
      best_next       = '{red: best_red, green: best_green, blue: best_blue};
      best_delta_next = best_delta;
      best_max_next   = best_max;
    end
    first_pending_next = first_pending && !candidate;
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pix_ready) begin
      in_valid <= pix_valid;
    end
    if (pix_ready && pix_valid) begin
      in_red   <= pix_red;
      in_green <= pix_green;
      in_blue  <= pix_blue;
      in_last  <= pix_last;
    end
  end

  // Tracking state; the last pixel of an icon rearms it.
  always_ff @(posedge clk) begin
    if (rst) begin
      stride_count  <= 16'd0;
      best_red      <= 8'd0;
      best_green    <= 8'd0;
      best_blue     <= 8'd0;
      best_delta    <= 8'd0;
      best_max      <= 8'd0;
      first_pending <= 1'b1;
    end else if (pop) begin
      if (in_last) begin
        stride_count  <= 16'd0;
        best_red      <= 8'd0;
        best_green    <= 8'd0;
        best_blue     <= 8'd0;
        best_delta    <= 8'd0;
        best_max      <= 8'd0;
        first_pending <= 1'b1;
      end else begin
        stride_count  <= stride_count_next;
        best_red      <= best_next.red;
        best_green    <= best_next.green;
        best_blue     <= best_next.blue;
        best_delta    <= best_delta_next;
        best_max      <= best_max_next;
        first_pending <= first_pending_next;
      end
    end
  end

  // Result slot toward the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= (cand_valid && !cand_ready) || (pop && in_last);
    end
    if (pop && in_last) begin
      cand <= best_next;
    end
  end

  `ASSERT_NEXT(a_no_spurious_result, clk, rst,
    (!cand_valid || cand_ready) && !(pop && in_last), !cand_valid)
  `ASSERT_NEXT(a_rearm_after_last, clk, rst,
    pop && in_last, first_pending && (stride_count == 16'd0))
  `ASSERT_IMPL(a_fresh_state_clear, clk, rst,
    first_pending, (best_delta == 8'd0) && (best_max == 8'd0))

endmodule

FILE: src/icp_tone.sv
// Brightness classing, darkening products and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icp_tone
  import icp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cand_valid,
  output logic        cand_ready,
  input  cand_t       cand,
  input  color_t      default_color,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [23:0] res_data,
  output logic [1:0]  res_user
);

  // Product stage.
  logic        c_valid;
  logic [16:0] p_red;
  logic [16:0] p_green;
  logic [16:0] p_blue;
  logic        c_bright;
  logic        c_dark;
  cand_t       c_rgb;

  logic        out_load;
  logic [9:0]  sum;
  logic [10:0] scale_full;
  logic [8:0]  scale;

  assign out_load   = c_valid && (!res_valid || res_ready);
  assign cand_ready = !c_valid || out_load;

  // Channel sum and darkening factor; the factor is only used for bright colors.
  always_comb begin
    sum        = 10'(cand.red) + 10'(cand.green) + 10'(cand.blue);
    scale_full = DARK_BASE - {sum, 1'b0};
    scale      = scale_full[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (cand_ready) begin
      c_valid <= cand_valid;
    end
    if (cand_ready && cand_valid) begin
      p_red    <= 17'(cand.red) * 17'(scale);
      p_green  <= 17'(cand.green) * 17'(scale);
      p_blue   <= 17'(cand.blue) * 17'(scale);
      c_bright <= (sum >= BRIGHT_SUM);
      c_dark   <= (sum <= DARK_SUM);
      c_rgb    <= cand;
    end
  end

  // Output register: divided products, default color or the color unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (out_load) begin
      if (c_bright) begin
        res_data <= {div510(p_blue), div510(p_green), div510(p_red)};
        res_user <= 2'b10;
      end else if (c_dark) begin
        res_data <= {default_color.blue, default_color.green, default_color.red};
        res_user <= 2'b01;
      end else begin
        res_data <= {c_rgb.blue, c_rgb.green, c_rgb.red};
        res_user <= 2'b00;
      end
    end
  end

  `ASSERT_IMPL(a_flags_exclusive, clk, rst, res_valid, !(res_user[0] && res_user[1]))
  `ASSERT_NEXT(a_stage_holds, clk, rst, c_valid && !out_load, c_valid && $stable(c_rgb))

endmodule

FILE: src/icon_accent_color_picker_core.sv
// Top level of the icon accent color picker: configuration registers and stages.
`timescale 1ns / 1ps
// Throughput: one pixel item per cycle; a last pixel waits in the input register only
// while three result items are already held downstream by a stalled receiver.
// After its last pixel is accepted, the result item passes the input register, the
// candidate slot, the darkening product stage and the output register.
// Reset (rst, synchronous, active high) empties all stages, rearms the tracker for
// a new icon and sets sample_stride to 1 and the default color to black.
module icon_accent_color_picker_core
  import icp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  input  logic                   s_axis_tlast,  // last_pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // accent_red [7:0], accent_green [15:8], accent_blue [23:16]
  output logic [23:0]            m_axis_tdata,
  output logic [1:0]             m_axis_tuser,  // used_default [0], was_darkened [1]
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0] sample_stride;
  color_t      default_color;
  logic        cand_valid;
  logic        cand_ready;
  cand_t       cand;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_stride <= STRIDE_RESET;
      default_color <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_STRIDE: sample_stride       <= cfg_data;
        REG_DEFAULT_RED:   default_color.red   <= cfg_data[7:0];
        REG_DEFAULT_GREEN: default_color.green <= cfg_data[7:0];
        REG_DEFAULT_BLUE:  default_color.blue  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  icp_select u_select (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (s_axis_tvalid),
    .pix_ready     (s_axis_tready),
    .pix_red       (s_axis_tdata[7:0]),
    .pix_green     (s_axis_tdata[15:8]),
    .pix_blue      (s_axis_tdata[23:16]),
    .pix_last      (s_axis_tlast),
    .sample_stride (sample_stride),
    .cand_valid    (cand_valid),
    .cand_ready    (cand_ready),
    .cand          (cand)
  );

  icp_tone u_tone (
    .clk           (clk),
    .rst           (rst),
    .cand_valid    (cand_valid),
    .cand_ready    (cand_ready),
    .cand          (cand),
    .default_color (default_color),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res_data      (m_axis_tdata),
    .res_user      (m_axis_tuser)
  );

endmodule
